[rtl/mvn_pkg.sv]
// ----------------------------------------------------------------------------
// mvn_pkg: shared types and constants of the mesh vertex normal engine
// Item layouts, the command passed from front to back, and sizes.
// ----------------------------------------------------------------------------
package mvn_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 11;
	localparam int COORD_W      = 16;
	localparam int NRM_W        = 16;
	localparam int SUM_W        = 24;
	localparam int Q_DEPTH      = 2;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TRI   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]                kind;
		logic [9:0]                vertex_index;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [9:0]                corner_a;
		logic [9:0]                corner_b;
		logic [9:0]                corner_c;
	} in_item_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    degenerate;
		logic                    index_error;
		logic                    from_query;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TRI,
		OP_QUERY,
		OP_ERR
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic                      is_query;
		logic [IDX_W-1:0]          idx;
		logic [IDX_W-1:0]          ca;
		logic [IDX_W-1:0]          cb;
		logic [IDX_W-1:0]          cc;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

[rtl/mvn_front.sv]
// ----------------------------------------------------------------------------
// mvn_front: input acceptance and classification
// Holds vertex_count, checks indexes and turns each item but the unused kind into a command.
// ----------------------------------------------------------------------------
module mvn_front import mvn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  back_stat_t       stat,
	input  logic             q_full,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] limit;
	logic             ok_v, ok_a, ok_b, ok_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cfg_valid) begin
			vcount_q <= cfg_data;
		end
	end

	assign limit = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
	assign ok_v  = CNT_W'(in_data.vertex_index) < limit;
	assign ok_a  = CNT_W'(in_data.corner_a) < limit;
	assign ok_b  = CNT_W'(in_data.corner_b) < limit;
	assign ok_c  = CNT_W'(in_data.corner_c) < limit;

	assign in_ready = !stat.clearing && !q_full;

	always_comb begin
		push_cmd          = '0;
		push_cmd.idx      = IDX_W'(in_data.vertex_index);
		push_cmd.ca       = IDX_W'(in_data.corner_a);
		push_cmd.cb       = IDX_W'(in_data.corner_b);
		push_cmd.cc       = IDX_W'(in_data.corner_c);
		push_cmd.px       = in_data.pos_x;
		push_cmd.py       = in_data.pos_y;
		push_cmd.pz       = in_data.pos_z;
		push_cmd.is_query = (in_data.kind == KIND_QUERY);
		unique case (in_data.kind)
			KIND_LOAD:  push_cmd.op = ok_v ? OP_LOAD : OP_ERR;
			KIND_TRI:   push_cmd.op = (ok_a && ok_b && ok_c) ? OP_TRI : OP_ERR;
			KIND_QUERY: push_cmd.op = ok_v ? OP_QUERY : OP_ERR;
			default:    push_cmd.op = OP_ERR;
		endcase
	end

	// drop the unused kind
	assign push = in_valid && in_ready && (in_data.kind != KIND_NONE);

endmodule

[rtl/mvn_queue.sv]
// ----------------------------------------------------------------------------
// mvn_queue: command queue between front and back
// Small FIFO so either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module mvn_queue import mvn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	cmd_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			for (int i = 0; i < Q_DEPTH; i++) mem_q[i] <= '0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= wdata;
				wr_q        <= (wr_q == PTR_W'(Q_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(Q_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/mvn_back.sv]
// ----------------------------------------------------------------------------
// mvn_back: command execution
// Vertex and accumulator memories, cross product, iterative normalize,
// square root and divide, accumulator update and the result register.
// ----------------------------------------------------------------------------
module mvn_back import mvn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output back_stat_t stat,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOAD, S_ERR, S_RD_A, S_RD_B, S_RD_C, S_EDGE,
		S_CROSS, S_Q_RD, S_Q_LAT, S_MAG, S_NORM, S_SQ, S_SQRT,
		S_DIV_INIT, S_DIV, S_EMIT, S_ACC_RD, S_ACC_WR
	} state_t;

	localparam int POS_W = 3*COORD_W;
	localparam int SW_W  = 3*SUM_W;
	localparam int E_W   = COORD_W+1;
	localparam int CR_W  = 2*E_W+2;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [IDX_W-1:0]         clr_addr_q;
	logic [POS_W-1:0]         pa_q, pb_q;
	logic signed [E_W-1:0]    e1_q [3];
	logic signed [E_W-1:0]    e2_q [3];
	logic signed [CR_W-1:0]   cr_q [3];
	logic [CR_W-1:0]          m_q  [3];
	logic                     neg_q [3];
	logic [3:0]               step_q;
	logic [1:0]               comp_q;
	logic [61:0]              s_q;
	logic [63:0]              rem_q, root_q, bit_q;
	logic [30:0]              len_q;
	logic [31:0]              part_q;
	logic [14:0]              low_q, quo_q;
	logic signed [NRM_W-1:0]  nrm_q [3];
	logic                     deg_q;
	out_item_t                out_q;
	logic                     out_valid_q;

	// memories
	logic [POS_W-1:0] pos_mem [MAX_VERTICES];
	logic [SW_W-1:0]  sum_mem [MAX_VERTICES];
	logic [POS_W-1:0] pos_rdata_q;
	logic [SW_W-1:0]  sum_rdata_q;
	logic [IDX_W-1:0] pos_raddr, sum_raddr, sum_waddr, corner;
	logic [SW_W-1:0]  sum_wdata;
	logic             pos_we, sum_we;

	// datapath
	logic signed [E_W-1:0]    opa, opb;
	logic signed [2*E_W-1:0]  prod;
	logic signed [CR_W-1:0]   prod_x;
	logic [CR_W-1:0]          abs_v [3];
	logic [CR_W-1:0]          mx_abs, mx_m;
	logic [59:0]              sq;
	logic [63:0]              sq_t;
	logic [44:0]              num;
	logic [31:0]              p2;
	logic                     ge;
	logic [14:0]              qfin;
	logic signed [NRM_W-1:0]  qsig;
	logic                     out_free;

	function automatic logic [CR_W-1:0] max3(logic [CR_W-1:0] a, logic [CR_W-1:0] b,
			logic [CR_W-1:0] c);
		logic [CR_W-1:0] t;
		t = (a > b) ? a : b;
		return (t > c) ? t : c;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s,
			logic signed [NRM_W-1:0] n);
		logic signed [SUM_W:0] r;
		r = $signed({s[SUM_W-1], s}) + (SUM_W+1)'(n);
		if (r > $signed((SUM_W+1)'((1 << (SUM_W-1)) - 1))) return {1'b0, {(SUM_W-1){1'b1}}};
		if (r < $signed({2'b11, {(SUM_W-1){1'b0}}})) return {1'b1, {(SUM_W-1){1'b0}}};
		return r[SUM_W-1:0];
	endfunction

	assign stat.clearing = (state_q == S_CLEAR);
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign out_free      = !out_valid_q || out_ready;
	assign q_pop         = (state_q == S_IDLE) && q_valid;

	always_comb begin
		case (comp_q)
			2'd0:    corner = cmd_q.ca;
			2'd1:    corner = cmd_q.cb;
			default: corner = cmd_q.cc;
		endcase
	end

	always_comb begin
		case (state_q)
			S_RD_A:  pos_raddr = cmd_q.ca;
			S_RD_B:  pos_raddr = cmd_q.cb;
			default: pos_raddr = cmd_q.cc;
		endcase
		sum_raddr = (state_q == S_Q_RD) ? cmd_q.idx : corner;
	end

	always_comb begin
		pos_we    = (state_q == S_LOAD);
		sum_we    = 1'b0;
		sum_waddr = cmd_q.idx;
		sum_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_addr_q;
			end
			S_LOAD: begin
				sum_we = 1'b1;
			end
			S_ACC_WR: begin
				sum_we    = 1'b1;
				sum_waddr = corner;
				sum_wdata = {sat_add(sum_rdata_q[SW_W-1 -: SUM_W], nrm_q[0]),
					sat_add(sum_rdata_q[2*SUM_W-1 -: SUM_W], nrm_q[1]),
					sat_add(sum_rdata_q[SUM_W-1:0], nrm_q[2])};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[cmd_q.idx] <= {cmd_q.px, cmd_q.py, cmd_q.pz};
		pos_rdata_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
		sum_rdata_q <= sum_mem[sum_raddr];
	end

	// cross product: one signed product per step, two steps per component
	always_comb begin
		case (step_q[2:0])
			3'd0:    begin opa = e1_q[1]; opb = e2_q[2]; end
			3'd1:    begin opa = e1_q[2]; opb = e2_q[1]; end
			3'd2:    begin opa = e1_q[2]; opb = e2_q[0]; end
			3'd3:    begin opa = e1_q[0]; opb = e2_q[2]; end
			3'd4:    begin opa = e1_q[0]; opb = e2_q[1]; end
			default: begin opa = e1_q[1]; opb = e2_q[0]; end
		endcase
		prod   = opa * opb;
		prod_x = CR_W'(prod);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_v[i] = cr_q[i][CR_W-1] ? CR_W'(-cr_q[i]) : CR_W'(cr_q[i]);
		end
		mx_abs = max3(abs_v[0], abs_v[1], abs_v[2]);
		mx_m   = max3(m_q[0], m_q[1], m_q[2]);
		sq     = m_q[comp_q][29:0] * m_q[comp_q][29:0];
		sq_t   = root_q + bit_q;
		num    = {m_q[comp_q][29:0], 14'b0} + 45'(len_q >> 1);
		p2     = {part_q[30:0], low_q[14]};
		ge     = p2 >= {1'b0, len_q};
		qfin   = {quo_q[13:0], ge};
		qsig   = neg_q[comp_q] ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cmd_q       <= '0;
			clr_addr_q  <= '0;
			pa_q        <= '0;
			pb_q        <= '0;
			step_q      <= '0;
			comp_q      <= '0;
			s_q         <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			bit_q       <= '0;
			len_q       <= '0;
			part_q      <= '0;
			low_q       <= '0;
			quo_q       <= '0;
			deg_q       <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				e1_q[i]  <= '0;
				e2_q[i]  <= '0;
				cr_q[i]  <= '0;
				m_q[i]   <= '0;
				neg_q[i] <= 1'b0;
				nrm_q[i] <= '0;
			end
		end else begin
			// the result states load the next beat themselves
			if (out_ready && state_q != S_ERR && state_q != S_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q  <= q_cmd;
						deg_q  <= 1'b0;
						step_q <= '0;
						comp_q <= '0;
						unique case (q_cmd.op)
							OP_LOAD:  state_q <= S_LOAD;
							OP_TRI:   state_q <= S_RD_A;
							OP_QUERY: state_q <= S_Q_RD;
							OP_ERR:   state_q <= S_ERR;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_ERR: begin
					if (out_free) begin
						out_q       <= '{normal_x: '0, normal_y: '0, normal_z: '0,
							degenerate: 1'b0, index_error: 1'b1, from_query: cmd_q.is_query};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					pa_q    <= pos_rdata_q;
					state_q <= S_RD_C;
				end
				S_RD_C: begin
					pb_q    <= pos_rdata_q;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= E_W'($signed(pa_q[POS_W-1-i*COORD_W -: COORD_W]))
							- E_W'($signed(pb_q[POS_W-1-i*COORD_W -: COORD_W]));
						e2_q[i] <= E_W'($signed(pb_q[POS_W-1-i*COORD_W -: COORD_W]))
							- E_W'($signed(pos_rdata_q[POS_W-1-i*COORD_W -: COORD_W]));
					end
					step_q  <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					if (!step_q[0]) cr_q[step_q[2:1]] <= prod_x;
					else cr_q[step_q[2:1]] <= cr_q[step_q[2:1]] - prod_x;
					step_q <= step_q + 1'b1;
					if (step_q == 4'd5) state_q <= S_MAG;
				end
				S_Q_RD: state_q <= S_Q_LAT;
				S_Q_LAT: begin
					for (int i = 0; i < 3; i++) begin
						cr_q[i] <= CR_W'($signed(sum_rdata_q[SW_W-1-i*SUM_W -: SUM_W]));
					end
					state_q <= S_MAG;
				end
				S_MAG: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]   <= abs_v[i];
						neg_q[i] <= cr_q[i][CR_W-1];
					end
					if (mx_abs == '0) begin
						deg_q   <= 1'b1;
						for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					// bring the largest magnitude into [2^29, 2^30)
					if (mx_m[CR_W-1:30] != '0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (!mx_m[29]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						s_q     <= '0;
						comp_q  <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					s_q    <= s_q + 62'(sq);
					comp_q <= comp_q + 1'b1;
					if (comp_q == 2'd2) begin
						rem_q   <= 64'(s_q) + 64'(sq);
						root_q  <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q == '0) begin
						len_q   <= root_q[30:0];
						comp_q  <= '0;
						state_q <= S_DIV_INIT;
					end else begin
						if (rem_q >= sq_t) begin
							rem_q  <= rem_q - sq_t;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_DIV_INIT: begin
					part_q  <= 32'(num[44:15]);
					low_q   <= num[14:0];
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					part_q <= ge ? p2 - {1'b0, len_q} : p2;
					quo_q  <= qfin;
					low_q  <= low_q << 1;
					step_q <= step_q + 1'b1;
					if (step_q == 4'd14) begin
						nrm_q[comp_q] <= qsig;
						comp_q        <= comp_q + 1'b1;
						state_q       <= (comp_q == 2'd2) ? S_EMIT : S_DIV_INIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q       <= '{normal_x: nrm_q[0], normal_y: nrm_q[1],
							normal_z: nrm_q[2], degenerate: deg_q, index_error: 1'b0,
							from_query: (cmd_q.op == OP_QUERY)};
						out_valid_q <= 1'b1;
						comp_q      <= '0;
						state_q     <= (cmd_q.op == OP_TRI && !deg_q) ? S_ACC_RD : S_IDLE;
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					comp_q  <= comp_q + 1'b1;
					state_q <= (comp_q == 2'd2) ? S_IDLE : S_ACC_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/mesh_vertex_normal_engine.sv]
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine: per-vertex normal averaging
// Face normals of triangles, accumulated per vertex, and normalized queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | in        | in_valid / in_ready  | in_item_t (load, triangle, query)
//  out     | out       | out_valid/out_ready  | out_item_t (normal and flags)
//  cfg     | in        | cfg_valid/cfg_ready  | vertex_count, 11 bits
//
//  A triangle or a query runs the shift search (one bit per cycle), a
//  32-step square root and three 15-step divides; a degenerate one skips
//  them and emits a zero normal. A held result stalls the next result state.
//  After reset all 1024 accumulator entries are cleared; in_ready stays
//  low meanwhile. A two-entry queue decouples input from execution.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine import mvn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	back_stat_t stat;
	logic       push, q_full, q_valid, q_pop;
	cmd_t       push_cmd, q_cmd;

	mvn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mvn_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_cmd)
	);

	mvn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

[rtl/mvn_checker.sv]
// ----------------------------------------------------------------------------
// mvn_props: port-level checks of the mesh vertex normal engine
// Result hold under stall, consistency of result flags and normals, and their range.
// ----------------------------------------------------------------------------
module mvn_props import mvn_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input out_item_t        out_data
);

	logic nrm_zero;
	assign nrm_zero = (out_data.normal_x == '0) && (out_data.normal_y == '0)
		&& (out_data.normal_z == '0);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.index_error |-> nrm_zero && !out_data.degenerate)
		else $error("index error beat with nonzero normal");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> nrm_zero && !out_data.index_error)
		else $error("degenerate beat with nonzero normal");

	a_nrm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384
			&& out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384
			&& out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384)
		else $error("normal component out of unit range");

endmodule

bind mesh_vertex_normal_engine mvn_props u_mvn_props (.*);

[tb/sv/mvn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_checker: result predictor and scoreboard for the vertex normal engine
// Watches the input, result and configuration channels and keeps its own
// copy of the vertex store, the accumulators and vertex_count. Each accepted
// triangle, query and rejected load yields an expected normal. Each result beat
// is compared field by field with the oldest expected normal.
// ----------------------------------------------------------------------------
module mvn_checker import mvn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output int               fails,
	output int               pending
);

	localparam int SAT_HI = 8388607;
	localparam int SAT_LO = -8388608;

	logic signed [COORD_W-1:0] vx [MAX_VERTICES];
	logic signed [COORD_W-1:0] vy [MAX_VERTICES];
	logic signed [COORD_W-1:0] vz [MAX_VERTICES];
	int                        acc_x [MAX_VERTICES];
	int                        acc_y [MAX_VERTICES];
	int                        acc_z [MAX_VERTICES];
	logic [CNT_W-1:0]          vcount;
	out_item_t                 normal_q [$];

	initial begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vx[i] = '0; vy[i] = '0; vz[i] = '0;
			acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
		end
		vcount = '0;
		fails = 0;
	end

	assign pending = normal_q.size();

	function automatic bit idx_valid(input logic [9:0] i);
		int lim;
		lim = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
		return int'(i) < lim;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic int sat_sum(input int a, input int b);
		int r;
		r = a + b;
		if (r > SAT_HI) r = SAT_HI;
		if (r < SAT_LO) r = SAT_LO;
		return r;
	endfunction

	function automatic out_item_t unit_vector(input longint x, input longint y,
	                                          input longint z, input bit q);
		out_item_t       o;
		longint unsigned m [3];
		bit              neg [3];
		longint unsigned mx, s, len, qt;
		longint          v [3];
		v[0] = x; v[1] = y; v[2] = z;
		o = '0;
		o.from_query = q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			mx = mx >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			mx = mx << 1;
		end
		s = 0;
		for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
		len = root_floor(s);
		for (int i = 0; i < 3; i++) begin
			qt = (64'd16384 * m[i] + len / 2) / len;
			v[i] = neg[i] ? -longint'(qt) : longint'(qt);
		end
		o.normal_x = v[0][15:0];
		o.normal_y = v[1][15:0];
		o.normal_z = v[2][15:0];
		return o;
	endfunction

	task automatic predict(input in_item_t it);
		out_item_t       o;
		longint          e1x, e1y, e1z, e2x, e2y, e2z;
		logic [9:0]      crn [3];
		o = '0;
		case (it.kind)
			KIND_LOAD: begin
				if (!idx_valid(it.vertex_index)) begin
					o.index_error = 1'b1;
					normal_q = {normal_q, o};
				end else begin
					vx[it.vertex_index] = it.pos_x;
					vy[it.vertex_index] = it.pos_y;
					vz[it.vertex_index] = it.pos_z;
					acc_x[it.vertex_index] = 0;
					acc_y[it.vertex_index] = 0;
					acc_z[it.vertex_index] = 0;
				end
			end
			KIND_TRI: begin
				if (!idx_valid(it.corner_a) || !idx_valid(it.corner_b) ||
				    !idx_valid(it.corner_c)) begin
					o.index_error = 1'b1;
				end else begin
					e1x = longint'(vx[it.corner_a]) - longint'(vx[it.corner_b]);
					e1y = longint'(vy[it.corner_a]) - longint'(vy[it.corner_b]);
					e1z = longint'(vz[it.corner_a]) - longint'(vz[it.corner_b]);
					e2x = longint'(vx[it.corner_b]) - longint'(vx[it.corner_c]);
					e2y = longint'(vy[it.corner_b]) - longint'(vy[it.corner_c]);
					e2z = longint'(vz[it.corner_b]) - longint'(vz[it.corner_c]);
					o = unit_vector(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
					                e1x * e2y - e1y * e2x, 1'b0);
					crn[0] = it.corner_a; crn[1] = it.corner_b; crn[2] = it.corner_c;
					// a repeated corner takes the normal once per position
					for (int k = 0; k < 3; k++) begin
						acc_x[crn[k]] = sat_sum(acc_x[crn[k]], int'(o.normal_x));
						acc_y[crn[k]] = sat_sum(acc_y[crn[k]], int'(o.normal_y));
						acc_z[crn[k]] = sat_sum(acc_z[crn[k]], int'(o.normal_z));
					end
				end
				normal_q = {normal_q, o};
			end
			KIND_QUERY: begin
				if (!idx_valid(it.vertex_index)) begin
					o.index_error = 1'b1;
					o.from_query = 1'b1;
				end else begin
					o = unit_vector(acc_x[it.vertex_index], acc_y[it.vertex_index],
					                acc_z[it.vertex_index], 1'b1);
				end
				normal_q = {normal_q, o};
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (normal_q.size() == 0) begin
					fails = fails + 1;
					if (fails <= 10)
						$display("unexpected result beat: %p", out_data);
				end else begin
					want = normal_q.pop_front();
					if (out_data.normal_x !== want.normal_x ||
					    out_data.normal_y !== want.normal_y ||
					    out_data.normal_z !== want.normal_z ||
					    out_data.degenerate !== want.degenerate ||
					    out_data.index_error !== want.index_error ||
					    out_data.from_query !== want.from_query) begin
						fails = fails + 1;
						if (fails <= 10)
							$display("mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				predict(in_data);
			if (cfg_valid && cfg_ready)
				vcount = cfg_data;
		end
	end

endmodule

[tb/sv/mesh_vertex_normal_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine_tb: stimulus and verdict for the normal engine
// Runs directed loads, triangles and queries at extreme coordinates and
// counts, a saturation phase on a tiny mesh, then random meshes, with random
// idling on both channels. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine_tb;
	import mvn_pkg::*;

	localparam int IN_W = $bits(in_item_t);

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;
	int               fails;
	int               pending;
	bit               no_idle;
	bit               loaded [MAX_VERTICES];
	int               lim;

	mesh_vertex_normal_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	mvn_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk)
		out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);

	function automatic in_item_t noise_item();
		in_item_t it;
		it = IN_W'({$urandom, $urandom, $urandom});
		return it;
	endfunction

	task automatic send(input in_item_t it);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load(input int i, input logic [15:0] x, input logic [15:0] y,
	                    input logic [15:0] z);
		in_item_t it;
		it = noise_item();
		it.kind = KIND_LOAD; it.vertex_index = 10'(i);
		it.pos_x = x; it.pos_y = y; it.pos_z = z;
		if (i < lim) loaded[i] = 1'b1;
		send(it);
	endtask

	task automatic tri_face(input int a, input int b, input int c);
		in_item_t it;
		it = noise_item();
		it.kind = KIND_TRI; it.corner_a = 10'(a); it.corner_b = 10'(b);
		it.corner_c = 10'(c);
		send(it);
	endtask

	task automatic query(input int i);
		in_item_t it;
		it = noise_item();
		it.kind = KIND_QUERY; it.vertex_index = 10'(i);
		send(it);
	endtask

	// drain results and let a trailing load finish before touching the register
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic set_count(input int v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= CNT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		lim = (v > MAX_VERTICES) ? MAX_VERTICES : v;
	endtask

	function automatic int pick_loaded();
		int i;
		for (int t = 0; t < 30; t++) begin
			i = $urandom_range(lim - 1);
			if (loaded[i]) return i;
		end
		return 0;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $urandom_range(2) == 0 ? 16'h7fff : 16'h8000;
			default: return 16'($urandom_range(1023) - 512);
		endcase
	endfunction

	task automatic random_mesh(input int count, input int items);
		int a, b, c, r;
		set_count(count);
		for (int i = 0; i < MAX_VERTICES; i++) loaded[i] = 1'b0;
		for (int i = 0; i < lim && i < 8; i++)
			load(i, rand_coord(), rand_coord(), rand_coord());
		for (int n = 0; n < items; n++) begin
			no_idle = (n >= items / 3 && n < items / 3 + 60);
			r = $urandom_range(99);
			if (r < 30) begin
				if (lim < MAX_VERTICES && $urandom_range(9) == 0)
					load($urandom_range(MAX_VERTICES - 1, lim), rand_coord(),
					     rand_coord(), rand_coord());
				else
					load($urandom_range(lim - 1), rand_coord(), rand_coord(),
					     rand_coord());
			end else if (r < 70) begin
				a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
				if (lim < MAX_VERTICES && $urandom_range(9) == 0)
					b = $urandom_range(MAX_VERTICES - 1, lim);
				tri_face(a, b, c);
			end else if (r < 95) begin
				if (lim < MAX_VERTICES && $urandom_range(9) == 0)
					query($urandom_range(MAX_VERTICES - 1, lim));
				else
					query($urandom_range(lim - 1));
			end else begin
				in_item_t it;
				it = noise_item();
				it.kind = KIND_NONE;
				send(it);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		no_idle   = 1'b0;
		lim       = 0;
		for (int i = 0; i < MAX_VERTICES; i++) loaded[i] = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// count of zero: every index is out of range
		load(0, 16'h0100, 16'h0200, 16'h0300);
		tri_face(0, 0, 0);
		query(0);

		// oversized count is limited to the store size
		set_count(2047);
		query(5);
		load(0, 16'h7fff, 16'h8000, 16'h0000);
		load(1, 16'h8000, 16'h7fff, 16'h7fff);
		load(1023, 16'h0000, 16'h8000, 16'h7fff);
		load(2, 16'h0100, 16'h0000, 16'h0000);
		load(3, 16'h0000, 16'h0100, 16'h0000);
		tri_face(0, 1, 1023);
		tri_face(2, 3, 0);
		tri_face(2, 2, 3);
		tri_face(1023, 1023, 1023);
		query(0);
		query(1);
		query(1023);
		query(4);
		begin
			in_item_t it;
			it = noise_item();
			it.kind = KIND_NONE;
			send(it);
		end
		// reload clears the accumulator
		load(0, 16'hff00, 16'h0001, 16'hffff);
		query(0);

		// tiny mesh driven into accumulator saturation
		set_count(3);
		load(0, 16'h0000, 16'h0000, 16'h0000);
		load(1, 16'h0100, 16'h0000, 16'h0000);
		load(2, 16'h0000, 16'h0100, 16'h0000);
		load(3, 16'h0000, 16'h0000, 16'h0000);
		for (int n = 0; n < 540; n++) begin
			no_idle = (n >= 100 && n < 200);
			if (n % 60 == 59) query($urandom_range(2));
			else tri_face(0, 1, 2);
		end
		no_idle = 1'b0;
		query(0);
		query(3);

		random_mesh(1024, 180);
		random_mesh(37, 130);
		random_mesh(1, 40);
		random_mesh(1024, 90);

		settle();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
rtl/mvn_pkg.sv
rtl/mvn_front.sv
rtl/mvn_queue.sv
rtl/mvn_back.sv
rtl/mesh_vertex_normal_engine.sv
rtl/mvn_checker.sv
tb/sv/mvn_checker.sv
tb/sv/mesh_vertex_normal_engine_tb.sv
